FILE: sv/pgrp_pkg.sv
// Shared types and constants of the page replacement policy block.
package pgrp_pkg;

  localparam int MAX_FRAMES = 32;
  localparam int FRAME_W    = 5;
  localparam int FCOUNT_W   = 6;
  localparam int PERIOD_W   = 8;
  localparam int STAMP_W    = 16;
  localparam int FAULT_W    = 16;
  localparam int PAGE_IN_W  = 5;
  localparam int PAGE_OUT_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_USED_W = 1 + FRAME_W + 1 + PAGE_OUT_W + FAULT_W;
  localparam int OUT_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_PERIOD = 2'd2;

  localparam logic [FCOUNT_W-1:0] FRAME_COUNT_RST  = 6'd4;
  localparam logic [PERIOD_W-1:0] CLEAR_PERIOD_RST = 8'd50;

  typedef enum logic [1:0] {
    POL_FIFO = 2'd0,
    POL_LRU  = 2'd1,
    POL_LFU  = 2'd2,
    POL_NUR  = 2'd3
  } policy_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DECIDE,
    ST_OWNER,
    ST_SCAN,
    ST_NUR,
    ST_VREAD,
    ST_VICT,
    ST_LOAD,
    ST_FINISH
  } pgrp_state_e;

  typedef struct packed {
    logic capture;
    logic decide;
    logic hit_update;
    logic fault;
    logic alloc;
    logic fifo_pick;
    logic scan_init;
    logic nur_init;
    logic take_owner;
    logic scan_run;
    logic nur_run;
    logic victim_read;
    logic evict;
    logic load;
    logic finish;
  } pgrp_cmd_t;

  typedef struct packed {
    logic    hit;
    logic    frame_free;
    policy_e policy;
    logic    scan_done;
    logic    nur_found;
    logic    out_free;
  } pgrp_sts_t;

endpackage

FILE: sv/pgrp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pgrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/pgrp_ctrl.sv
// Sequencer that steps the datapath through lookup, victim search, load and result.
module pgrp_ctrl import pgrp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pgrp_sts_t sts_i,
  output pgrp_cmd_t cmd_o
);

  pgrp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_READ;
      end
      ST_READ: state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (sts_i.hit) begin
          state_d = ST_FINISH;
        end else if (sts_i.frame_free) begin
          state_d = ST_LOAD;
        end else begin
          unique case (sts_i.policy)
            POL_FIFO: state_d = ST_OWNER;
            POL_LRU:  state_d = ST_SCAN;
            POL_LFU:  state_d = ST_SCAN;
            POL_NUR:  state_d = ST_NUR;
            default:  state_d = ST_OWNER;
          endcase
        end
      end
      ST_OWNER: state_d = ST_VREAD;
      ST_SCAN: begin
        if (sts_i.scan_done) state_d = ST_VREAD;
      end
      ST_NUR: begin
        if (sts_i.nur_found) state_d = ST_VREAD;
      end
      ST_VREAD: state_d = ST_VICT;
      ST_VICT:  state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_FINISH;
      ST_FINISH: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_READ: ;
      ST_DECIDE: begin
        cmd_o.decide     = 1'b1;
        cmd_o.hit_update = sts_i.hit;
        cmd_o.fault      = !sts_i.hit;
        cmd_o.alloc      = !sts_i.hit && sts_i.frame_free;
        if (!sts_i.hit && !sts_i.frame_free) begin
          cmd_o.fifo_pick = (sts_i.policy == POL_FIFO);
          cmd_o.scan_init = (sts_i.policy == POL_LRU) || (sts_i.policy == POL_LFU);
          cmd_o.nur_init  = (sts_i.policy == POL_NUR);
        end
      end
      ST_OWNER:  cmd_o.take_owner  = 1'b1;
      ST_SCAN:   cmd_o.scan_run    = 1'b1;
      ST_NUR:    cmd_o.nur_run     = 1'b1;
      ST_VREAD:  cmd_o.victim_read = 1'b1;
      ST_VICT:   cmd_o.evict       = 1'b1;
      ST_LOAD:   cmd_o.load        = 1'b1;
      ST_FINISH: cmd_o.finish      = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

FILE: sv/pgrp_dp.sv
// Datapath with page state, bookkeeping registers, RAMs and the result register.
module pgrp_dp import pgrp_pkg::*; #(
  parameter int VIRTUAL_PAGES = 32,
  parameter int COUNT_WIDTH   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [PAGE_IN_W-1:0]  in_page_i,
  input  pgrp_cmd_t             cmd_i,
  output pgrp_sts_t             sts_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  localparam int PW        = $clog2(VIRTUAL_PAGES);
  localparam int KW        = (COUNT_WIDTH > STAMP_W) ? COUNT_WIDTH : STAMP_W;
  localparam int MW        = (PW + 1 > PAGE_IN_W) ? PW + 1 : PAGE_IN_W;
  localparam int MOD_STEPS = (2 ** PAGE_IN_W - 1) / VIRTUAL_PAGES;
  localparam logic [PW:0]   VP_C      = (PW + 1)'(VIRTUAL_PAGES);
  localparam logic [PW-1:0] LAST_PAGE = PW'(VIRTUAL_PAGES - 1);

  // Configuration.
  logic [FCOUNT_W-1:0] frame_count_q;
  policy_e             policy_q;
  logic [PERIOD_W-1:0] clear_period_q;

  // Control state.
  logic [VIRTUAL_PAGES-1:0] resident_q, resident_d;
  logic [VIRTUAL_PAGES-1:0] ref_q, ref_d;
  logic [FCOUNT_W-1:0]      alloc_q, alloc_d;
  logic [FRAME_W-1:0]       fifo_q, fifo_d;
  logic [PW-1:0]            clock_q, clock_d;
  logic [PW-1:0]            nur_start_q, nur_start_d;
  logic [STAMP_W-1:0]       time_q, time_d;
  logic [PERIOD_W-1:0]      ref_idx_q, ref_idx_d;
  logic [FAULT_W-1:0]       faults_q, faults_d;
  logic [PW:0]              scan_q, scan_d;
  logic                     cmp_valid_q, cmp_valid_d;
  logic                     found_q, found_d;
  logic                     out_valid_q, out_valid_d;

  // Payload.
  logic [PW-1:0]         p_q, p_d;
  logic [PW-1:0]         v_q, v_d;
  logic [FRAME_W-1:0]    f_q, f_d;
  logic                  hit_q, hit_d;
  logic                  ev_q, ev_d;
  logic [PW-1:0]         cmp_idx_q, cmp_idx_d;
  logic [KW-1:0]         best_q, best_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  // Combinational helpers.
  logic [MW-1:0]            pg_mod;
  logic [FCOUNT_W-1:0]      frames_n;
  logic [FRAME_W-1:0]       fifo_idx, fifo_next;
  logic [FCOUNT_W-1:0]      fifo_inc;
  logic [PW-1:0]            clock_next;
  logic                     nur_hit;
  logic [PERIOD_W:0]        idx_inc, period;
  logic [STAMP_W-1:0]       age;
  logic [COUNT_WIDTH-1:0]   cnt_inv;
  logic [KW-1:0]            key;
  logic [PW+PAGE_OUT_W-1:0] v_wide;
  logic [PAGE_OUT_W-1:0]    evp;

  // RAM ports.
  logic [FRAME_W-1:0]     frame_rd;
  logic [PW-1:0]          frame_raddr;
  logic [PW-1:0]          owner_rd;
  logic [STAMP_W-1:0]     stamp_rd;
  logic [COUNT_WIDTH-1:0] cnt_rd, cnt_wdata;
  logic [PW-1:0]          cnt_waddr, sweep_raddr;
  logic                   cnt_we;

  always_comb begin
    pg_mod = MW'(in_page_i);
    for (int k = 0; k < MOD_STEPS; k++) begin
      if (pg_mod >= MW'(VIRTUAL_PAGES)) pg_mod = pg_mod - MW'(VIRTUAL_PAGES);
    end
  end

  always_comb begin
    priority if (frame_count_q == '0) begin
      frames_n = FCOUNT_W'(1);
    end else if (frame_count_q > FCOUNT_W'(MAX_FRAMES)) begin
      frames_n = FCOUNT_W'(MAX_FRAMES);
    end else begin
      frames_n = frame_count_q;
    end
  end

  assign fifo_idx   = ({1'b0, fifo_q} >= frames_n) ? '0 : fifo_q;
  assign fifo_inc   = {1'b0, fifo_idx} + 1'b1;
  assign fifo_next  = (fifo_inc >= frames_n) ? '0 : fifo_inc[FRAME_W-1:0];
  assign clock_next = (clock_q == LAST_PAGE) ? '0 : clock_q + 1'b1;
  assign nur_hit    = resident_q[clock_q] && !ref_q[clock_q];
  assign idx_inc    = {1'b0, ref_idx_q} + 1'b1;
  assign period     = (clear_period_q == '0) ? (PERIOD_W + 1)'(1) : {1'b0, clear_period_q};
  assign age        = time_q - stamp_rd;
  assign cnt_inv    = ~cnt_rd;
  assign key        = (policy_q == POL_LRU) ? KW'(age) : KW'(cnt_inv);
  assign v_wide     = {{PAGE_OUT_W{1'b0}}, v_q};
  assign evp        = ev_q ? v_wide[PAGE_OUT_W-1:0] : '0;

  assign frame_raddr = cmd_i.victim_read ? v_q : p_q;
  assign sweep_raddr = (cmd_i.scan_run && (scan_q < VP_C)) ? scan_q[PW-1:0] : p_q;
  assign cnt_we      = cmd_i.hit_update || cmd_i.evict || cmd_i.load;
  assign cnt_waddr   = cmd_i.evict ? v_q : p_q;

  always_comb begin
    priority if (cmd_i.hit_update) begin
      cnt_wdata = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;
    end else if (cmd_i.evict) begin
      cnt_wdata = '0;
    end else begin
      cnt_wdata = COUNT_WIDTH'(1);
    end
  end

  pgrp_ram #(.WIDTH(FRAME_W), .DEPTH(VIRTUAL_PAGES)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (p_q),
    .wdata_i (f_q),
    .raddr_i (frame_raddr),
    .rdata_o (frame_rd)
  );

  pgrp_ram #(.WIDTH(PW), .DEPTH(MAX_FRAMES)) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (f_q),
    .wdata_i (p_q),
    .raddr_i (fifo_idx),
    .rdata_o (owner_rd)
  );

  pgrp_ram #(.WIDTH(STAMP_W), .DEPTH(VIRTUAL_PAGES)) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.finish),
    .waddr_i (p_q),
    .wdata_i (time_q),
    .raddr_i (sweep_raddr),
    .rdata_o (stamp_rd)
  );

  pgrp_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(VIRTUAL_PAGES)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (sweep_raddr),
    .rdata_o (cnt_rd)
  );

  always_comb begin
    resident_d  = resident_q;
    ref_d       = ref_q;
    alloc_d     = alloc_q;
    fifo_d      = fifo_q;
    clock_d     = clock_q;
    nur_start_d = nur_start_q;
    time_d      = time_q;
    ref_idx_d   = ref_idx_q;
    faults_d    = faults_q;
    scan_d      = scan_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    p_d         = p_q;
    v_d         = v_q;
    f_d         = f_q;
    hit_d       = hit_q;
    ev_d        = ev_q;
    best_d      = best_q;
    out_data_d  = out_data_q;
    cmp_valid_d = cmd_i.scan_run && (scan_q < VP_C);
    cmp_idx_d   = scan_q[PW-1:0];

    if (cmd_i.capture) p_d = pg_mod[PW-1:0];
    if (cmd_i.decide) begin
      hit_d = resident_q[p_q];
      ev_d  = 1'b0;
    end
    if (cmd_i.hit_update) begin
      f_d        = frame_rd;
      ref_d[p_q] = 1'b1;
    end
    if (cmd_i.fault && (faults_q != '1)) faults_d = faults_q + 1'b1;
    if (cmd_i.alloc) begin
      f_d     = alloc_q[FRAME_W-1:0];
      alloc_d = alloc_q + 1'b1;
    end
    if (cmd_i.fifo_pick) fifo_d = fifo_next;
    if (cmd_i.scan_init) begin
      scan_d  = '0;
      found_d = 1'b0;
    end
    if (cmd_i.nur_init) nur_start_d = clock_q;
    if (cmd_i.take_owner) v_d = owner_rd;
    if (cmd_i.scan_run) begin
      if (scan_q < VP_C) scan_d = scan_q + 1'b1;
      if (cmp_valid_q && resident_q[cmp_idx_q] && (!found_q || (key > best_q))) begin
        found_d = 1'b1;
        best_d  = key;
        v_d     = cmp_idx_q;
      end
    end
    if (cmd_i.nur_run) begin
      if (nur_hit) begin
        v_d = clock_q;
      end else begin
        clock_d = clock_next;
        if (clock_next == nur_start_q) ref_d = '0;
      end
    end
    if (cmd_i.evict) begin
      f_d             = frame_rd;
      resident_d[v_q] = 1'b0;
      ev_d            = 1'b1;
    end
    if (cmd_i.load) resident_d[p_q] = 1'b1;

    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.finish) begin
      time_d = time_q + 1'b1;
      if (ref_idx_q == '0) ref_d = '0;
      ref_idx_d   = (idx_inc >= period) ? '0 : idx_inc[PERIOD_W-1:0];
      out_valid_d = 1'b1;
      out_data_d  = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, faults_q, evp, ev_q, f_q, hit_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q  <= FRAME_COUNT_RST;
      policy_q       <= POL_FIFO;
      clear_period_q <= CLEAR_PERIOD_RST;
      resident_q     <= '0;
      ref_q          <= '0;
      alloc_q        <= '0;
      fifo_q         <= '0;
      clock_q        <= '0;
      nur_start_q    <= '0;
      time_q         <= '0;
      ref_idx_q      <= '0;
      faults_q       <= '0;
      scan_q         <= '0;
      cmp_valid_q    <= 1'b0;
      found_q        <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_FRAME_COUNT:  frame_count_q  <= cfg_data_i[FCOUNT_W-1:0];
          CFG_POLICY_MODE:  policy_q       <= policy_e'(cfg_data_i[1:0]);
          CFG_CLEAR_PERIOD: clear_period_q <= cfg_data_i[PERIOD_W-1:0];
          default: ;
        endcase
      end
      resident_q  <= resident_d;
      ref_q       <= ref_d;
      alloc_q     <= alloc_d;
      fifo_q      <= fifo_d;
      clock_q     <= clock_d;
      nur_start_q <= nur_start_d;
      time_q      <= time_d;
      ref_idx_q   <= ref_idx_d;
      faults_q    <= faults_d;
      scan_q      <= scan_d;
      cmp_valid_q <= cmp_valid_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q        <= p_d;
    v_q        <= v_d;
    f_q        <= f_d;
    hit_q      <= hit_d;
    ev_q       <= ev_d;
    cmp_idx_q  <= cmp_idx_d;
    best_q     <= best_d;
    out_data_q <= out_data_d;
  end

  assign sts_o.hit        = resident_q[p_q];
  assign sts_o.frame_free = alloc_q < frames_n;
  assign sts_o.policy     = policy_q;
  assign sts_o.scan_done  = cmp_valid_q && (cmp_idx_q == LAST_PAGE);
  assign sts_o.nur_found  = nur_hit;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: sv/page_replacement_policy.sv
// Top level of the page replacement policy block.
// One page reference is taken per transfer and answered by one result transfer. A hit goes
// from the lookup to the result; a fault into a free frame loads the page first, and a FIFO
// eviction reads the owner of the oldest frame, evicts it and then loads. LRU and LFU evictions
// sweep the stamp or use-count RAM one page per cycle through its single registered read port.
// A not-used-recently eviction steps the clock pointer one page per cycle. One reference is in
// work at a time; the next is accepted once the result has been placed in the output register,
// which holds it until the downstream side takes it.
module page_replacement_policy import pgrp_pkg::*; #(
  parameter int VIRTUAL_PAGES = 32,
  parameter int COUNT_WIDTH   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0: page_number, then zero padding.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0: hit, frame_number, evicted, evicted_page, fault_count, zero padding.
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  pgrp_cmd_t cmd;
  pgrp_sts_t sts;

  pgrp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pgrp_dp #(
    .VIRTUAL_PAGES (VIRTUAL_PAGES),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_page_i   (s_axis_tdata[PAGE_IN_W-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

  a_one_in_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("A second reference was taken while one was in work.");

  a_finish_has_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> sts.out_free)
    else $error("A result was written over one that was not yet taken.");

  a_hit_no_evict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[6])
    else $error("A hit reported an eviction.");

  a_no_evict_zero_page : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[6] |-> (m_axis_tdata[11:7] == '0))
    else $error("An evicted page was reported without an eviction.");

endmodule
